### rtl/core/block_mosaic_averager_macros.svh
// ---------------------------------------------------------------------------
// Block mosaic averager assertion macros
// Shorthand for clocked assertions that are disabled while reset is held.
// ---------------------------------------------------------------------------
`ifndef BLOCK_MOSAIC_AVERAGER_MACROS_SVH
`define BLOCK_MOSAIC_AVERAGER_MACROS_SVH

// Overlapping implication, checked on every rising clock edge out of reset.
`define BMA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define BMA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/bma_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Block mosaic averager package
// Word types of the pixel and result channels, lane control, register indices and default limits.
// ---------------------------------------------------------------------------
package bma_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_MAX_BLOCK  = 100;

    localparam logic [1:0] REG_BLOCK_SIZE   = 2'd0;
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_start;
    } pixel_t;

    typedef struct packed {
        logic [9:0] block_col;
        logic [9:0] block_row;
        logic [7:0] avg_red;
        logic [7:0] avg_green;
        logic [7:0] avg_blue;
        logic       frame_done;
    } result_t;

    typedef struct packed {
        logic rd_en;
        logic acc_en;
        logic first;
        logic div_step;
    } lane_ctl_t;

endpackage

### rtl/core/bma_lane.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Block mosaic averager channel lane
// Column sum memory for one color channel and a bit-serial divider.
// ---------------------------------------------------------------------------
module bma_lane #(
    parameter int MAX_WIDTH = bma_pkg::DEF_MAX_WIDTH,
    parameter int MAX_BLOCK = bma_pkg::DEF_MAX_BLOCK,
    localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    localparam int OB_W  = $clog2(MAX_BLOCK + 1),
    localparam int CNT_W = 2 * OB_W
) (
    input  logic               aclk,
    input  bma_pkg::lane_ctl_t ctl,
    input  logic [XW-1:0]      rd_addr,
    input  logic [XW-1:0]      wr_addr,
    input  logic [7:0]         pix,
    input  logic [CNT_W-1:0]   cnt,
    output logic [7:0]         avg
);
    import bma_pkg::*;

    localparam int SUM_W = 8 + CNT_W;
    localparam int DIV_W = CNT_W + 7;

    logic [SUM_W-1:0] mem [MAX_WIDTH];
    logic [SUM_W-1:0] rd_data_reg;
    logic [SUM_W-1:0] sum_next;
    logic [SUM_W-1:0] rem_reg;
    logic [DIV_W-1:0] div_reg;
    logic [7:0]       quot_reg;
    logic             fits;

    assign sum_next = ctl.first ? SUM_W'(pix) : rd_data_reg + SUM_W'(pix);
    assign fits     = rem_reg >= SUM_W'(div_reg);
    assign avg      = quot_reg;

    always_ff @(posedge aclk) begin
        if (ctl.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
        if (ctl.acc_en) begin
            mem[wr_addr] <= sum_next;
            rem_reg      <= sum_next;
            div_reg      <= {cnt, 7'b0};
            quot_reg     <= '0;
        end else if (ctl.div_step) begin
            if (fits) begin
                rem_reg <= rem_reg - SUM_W'(div_reg);
            end
            quot_reg <= {quot_reg[6:0], fits};
            div_reg  <= div_reg >> 1;
        end
    end

endmodule

### rtl/core/bma_out.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Block mosaic averager merge stage
// Joins the lane averages with the block coordinates into one result word.
// ---------------------------------------------------------------------------
module bma_out (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  logic [9:0]        block_col,
    input  logic [9:0]        block_row,
    input  logic [7:0]        avg_red,
    input  logic [7:0]        avg_green,
    input  logic [7:0]        avg_blue,
    input  logic              frame_done,
    output logic              can_load,
    output logic              m_valid,
    input  logic              m_ready,
    output bma_pkg::result_t  m_data
);
    import bma_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    assign can_load = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_data   = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load && can_load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && can_load) begin
            data_reg.block_col  <= block_col;
            data_reg.block_row  <= block_row;
            data_reg.avg_red    <= avg_red;
            data_reg.avg_green  <= avg_green;
            data_reg.avg_blue   <= avg_blue;
            data_reg.frame_done <= frame_done;
        end
    end

endmodule

### rtl/core/block_mosaic_averager.sv
`timescale 1ns / 1ps
// A block's result word is valid once its last pixel has passed the accumulate, divide and push states.
// A new pixel is accepted only in the idle state, once the previous one is accumulated; a block's
// last pixel also waits on the 8-step serial divider in each color lane, and on m_ready.
// The sum memories are read in the cycle before they are updated.
// Reset is synchronous, active low; it clears control and position and restores the configuration defaults.
// ---------------------------------------------------------------------------
// Block mosaic averager
// Sums RGB pixels per block column and emits truncated block averages.
// ---------------------------------------------------------------------------
module block_mosaic_averager #(
    parameter int MAX_WIDTH  = bma_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bma_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_BLOCK  = bma_pkg::DEF_MAX_BLOCK
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  bma_pkg::pixel_t  s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output bma_pkg::result_t m_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [10:0]      cfg_data
);
    import bma_pkg::*;

    localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int OB_W  = $clog2(MAX_BLOCK + 1);
    localparam int CNT_W = 2 * OB_W;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_ACC  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_PUSH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [6:0]  cfg_bs_reg;
    logic [10:0] cfg_w_reg;
    logic [10:0] cfg_h_reg;

    logic [XW-1:0]   col_cnt_reg, bcol_reg;
    logic [YW-1:0]   row_cnt_reg, brow_reg;
    logic [OB_W-1:0] ox_reg, oy_reg;

    logic [XW-1:0]    addr_reg;
    logic [YW-1:0]    brow_out_reg;
    logic             first_reg;
    logic             emit_reg;
    logic             frame_done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [7:0]       red_reg, green_reg, blue_reg;
    logic [2:0]       step_reg;

    logic            accept, cfg_write, can_load;
    logic [OB_W-1:0] bs_eff;
    logic [XW:0]     w_eff;
    logic [YW:0]     h_eff;
    logic [XW-1:0]   cc, bc;
    logic [YW-1:0]   rc, br;
    logic [OB_W-1:0] ox, oy, ox_p1, oy_p1;
    logic            row_end, col_end, last_row, block_bottom;
    lane_ctl_t       ctl;
    logic [7:0]      avg_r, avg_g, avg_b;

    assign accept    = s_valid && s_ready;
    assign cfg_ready = aresetn;
    assign cfg_write = cfg_valid && cfg_ready;
    assign s_ready   = aresetn && (state_reg == ST_IDLE);

    always_comb begin
        if (cfg_bs_reg == '0) begin
            bs_eff = OB_W'(1);
        end else if (32'(cfg_bs_reg) > MAX_BLOCK) begin
            bs_eff = OB_W'(MAX_BLOCK);
        end else begin
            bs_eff = OB_W'(cfg_bs_reg);
        end
        if (cfg_w_reg == '0) begin
            w_eff = (XW + 1)'(1);
        end else if (32'(cfg_w_reg) > MAX_WIDTH) begin
            w_eff = (XW + 1)'(MAX_WIDTH);
        end else begin
            w_eff = (XW + 1)'(cfg_w_reg);
        end
        if (cfg_h_reg == '0) begin
            h_eff = (YW + 1)'(1);
        end else if (32'(cfg_h_reg) > MAX_HEIGHT) begin
            h_eff = (YW + 1)'(MAX_HEIGHT);
        end else begin
            h_eff = (YW + 1)'(cfg_h_reg);
        end
    end

    assign cc = s_data.frame_start ? '0 : col_cnt_reg;
    assign rc = s_data.frame_start ? '0 : row_cnt_reg;
    assign bc = s_data.frame_start ? '0 : bcol_reg;
    assign br = s_data.frame_start ? '0 : brow_reg;
    assign ox = s_data.frame_start ? '0 : ox_reg;
    assign oy = s_data.frame_start ? '0 : oy_reg;

    assign ox_p1        = ox + 1'b1;
    assign oy_p1        = oy + 1'b1;
    assign row_end      = ((XW + 1)'(cc) + 1'b1) >= w_eff;
    assign last_row     = ((YW + 1)'(rc) + 1'b1) >= h_eff;
    assign col_end      = row_end || (ox_p1 >= bs_eff);
    assign block_bottom = last_row || (oy_p1 >= bs_eff);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_bs_reg  <= 7'd1;
            cfg_w_reg   <= 11'd1024;
            cfg_h_reg   <= 11'd1024;
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            bcol_reg    <= '0;
            brow_reg    <= '0;
            ox_reg      <= '0;
            oy_reg      <= '0;
        end else if (cfg_write) begin
            unique case (cfg_index)
                REG_BLOCK_SIZE:   cfg_bs_reg <= cfg_data[6:0];
                REG_IMAGE_WIDTH:  cfg_w_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: cfg_h_reg  <= cfg_data;
                default: ;
            endcase
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            bcol_reg    <= '0;
            brow_reg    <= '0;
            ox_reg      <= '0;
            oy_reg      <= '0;
        end else if (accept) begin
            if (row_end) begin
                col_cnt_reg <= '0;
                ox_reg      <= '0;
                bcol_reg    <= '0;
                if (last_row) begin
                    row_cnt_reg <= '0;
                    oy_reg      <= '0;
                    brow_reg    <= '0;
                end else begin
                    row_cnt_reg <= rc + 1'b1;
                    if (oy_p1 >= bs_eff) begin
                        oy_reg   <= '0;
                        brow_reg <= br + 1'b1;
                    end else begin
                        oy_reg   <= oy_p1;
                        brow_reg <= br;
                    end
                end
            end else begin
                col_cnt_reg <= cc + 1'b1;
                row_cnt_reg <= rc;
                oy_reg      <= oy;
                brow_reg    <= br;
                if (col_end) begin
                    ox_reg   <= '0;
                    bcol_reg <= bc + 1'b1;
                end else begin
                    ox_reg   <= ox_p1;
                    bcol_reg <= bc;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            addr_reg       <= bc;
            brow_out_reg   <= br;
            first_reg      <= (ox == '0) && (oy == '0);
            cnt_reg        <= CNT_W'(ox_p1) * CNT_W'(oy_p1);
            red_reg        <= s_data.red;
            green_reg      <= s_data.green;
            blue_reg       <= s_data.blue;
            frame_done_reg <= row_end && last_row;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            emit_reg <= 1'b0;
        end else if (accept) begin
            emit_reg <= col_end && block_bottom;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_ACC;
            ST_ACC:  state_next = emit_reg ? ST_DIV : ST_IDLE;
            ST_DIV:  if (step_reg == 3'd7) state_next = ST_PUSH;
            ST_PUSH: if (can_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_DIV) begin
                step_reg <= step_reg + 1'b1;
            end else begin
                step_reg <= '0;
            end
        end
    end

    assign ctl.rd_en    = accept;
    assign ctl.acc_en   = (state_reg == ST_ACC);
    assign ctl.first    = first_reg;
    assign ctl.div_step = (state_reg == ST_DIV);

    bma_lane #(.MAX_WIDTH(MAX_WIDTH), .MAX_BLOCK(MAX_BLOCK)) u_lane_red (
        .aclk(aclk), .ctl(ctl), .rd_addr(bc), .wr_addr(addr_reg),
        .pix(red_reg), .cnt(cnt_reg), .avg(avg_r)
    );

    bma_lane #(.MAX_WIDTH(MAX_WIDTH), .MAX_BLOCK(MAX_BLOCK)) u_lane_green (
        .aclk(aclk), .ctl(ctl), .rd_addr(bc), .wr_addr(addr_reg),
        .pix(green_reg), .cnt(cnt_reg), .avg(avg_g)
    );

    bma_lane #(.MAX_WIDTH(MAX_WIDTH), .MAX_BLOCK(MAX_BLOCK)) u_lane_blue (
        .aclk(aclk), .ctl(ctl), .rd_addr(bc), .wr_addr(addr_reg),
        .pix(blue_reg), .cnt(cnt_reg), .avg(avg_b)
    );

    bma_out u_out (
        .aclk(aclk),
        .aresetn(aresetn),
        .load(state_reg == ST_PUSH),
        .block_col(10'(addr_reg)),
        .block_row(10'(brow_out_reg)),
        .avg_red(avg_r),
        .avg_green(avg_g),
        .avg_blue(avg_b),
        .frame_done(frame_done_reg),
        .can_load(can_load),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data)
    );

`include "block_mosaic_averager_macros.svh"

    `BMA_ASSERT_NEXT(a_accept_to_acc, accept, state_reg == ST_ACC, "accepted word not accumulated")
    `BMA_ASSERT_NEXT(a_div_to_push, (state_reg == ST_DIV) && (step_reg == 3'd7), state_reg == ST_PUSH, "divider overran")
    `BMA_ASSERT_SAME(a_block_in_row, 1'b1, bcol_reg <= col_cnt_reg, "block column ahead of pixel column")

endmodule

### tb/block_mosaic_averager_check.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Block mosaic averager checker
// Watches the pixel, result and register channels. It keeps its own copy of
// the block column sums and raster position, predicts each block average
// and compares every result word with the oldest prediction.
// ---------------------------------------------------------------------------
module block_mosaic_averager_check (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_ready,
    input  bma_pkg::pixel_t  s_data,
    input  logic             m_valid,
    input  logic             m_ready,
    input  bma_pkg::result_t m_data,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [10:0]      cfg_data,
    output int               errors,
    output int               pending
);
    import bma_pkg::*;

    localparam int SUM_MASK = 32'h3F_FFFF;

    result_t    block_avg_q[$];
    logic [6:0]  blk_size_reg;
    logic [10:0] img_width_reg;
    logic [10:0] img_height_reg;
    int sum_red[DEF_MAX_WIDTH];
    int sum_green[DEF_MAX_WIDTH];
    int sum_blue[DEF_MAX_WIDTH];
    int pix_x, pix_y, off_x, off_y, blk_col, blk_row;

    initial errors = 0;

    task automatic report(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        errors++;
    endtask

    function automatic int limit_reg(input int v, input int hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    task automatic home_position();
        pix_x = 0;
        pix_y = 0;
        off_x = 0;
        off_y = 0;
        blk_col = 0;
        blk_row = 0;
    endtask

    task automatic accumulate_pixel(input pixel_t px);
        int      bsz, wd, ht, col, cnt;
        bit      row_end, col_end, last_row, blk_bottom;
        result_t avg;
        bsz = limit_reg(blk_size_reg, DEF_MAX_BLOCK);
        wd  = limit_reg(img_width_reg, DEF_MAX_WIDTH);
        ht  = limit_reg(img_height_reg, DEF_MAX_HEIGHT);
        if (px.frame_start) home_position();
        col = blk_col % DEF_MAX_WIDTH;
        if (off_x == 0 && off_y == 0) begin
            sum_red[col]   = px.red;
            sum_green[col] = px.green;
            sum_blue[col]  = px.blue;
        end else begin
            sum_red[col]   = (sum_red[col] + px.red) & SUM_MASK;
            sum_green[col] = (sum_green[col] + px.green) & SUM_MASK;
            sum_blue[col]  = (sum_blue[col] + px.blue) & SUM_MASK;
        end
        row_end    = (pix_x + 1 >= wd);
        col_end    = row_end || (off_x + 1 >= bsz);
        last_row   = (pix_y + 1 >= ht);
        blk_bottom = last_row || (off_y + 1 >= bsz);
        if (col_end && blk_bottom) begin
            cnt = (off_x + 1) * (off_y + 1);
            avg.block_col  = blk_col[9:0];
            avg.block_row  = blk_row[9:0];
            avg.avg_red    = 8'(sum_red[col] / cnt);
            avg.avg_green  = 8'(sum_green[col] / cnt);
            avg.avg_blue   = 8'(sum_blue[col] / cnt);
            avg.frame_done = row_end && last_row;
            block_avg_q.push_back(avg);
        end
        if (row_end) begin
            pix_x = 0;
            off_x = 0;
            blk_col = 0;
            if (last_row) begin
                pix_y = 0;
                off_y = 0;
                blk_row = 0;
            end else begin
                pix_y++;
                if (off_y + 1 >= bsz) begin
                    off_y = 0;
                    blk_row++;
                end else begin
                    off_y++;
                end
            end
        end else begin
            pix_x++;
            if (col_end) begin
                off_x = 0;
                blk_col++;
            end else begin
                off_x++;
            end
        end
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            blk_size_reg   = 7'd1;
            img_width_reg  = 11'd1024;
            img_height_reg = 11'd1024;
            home_position();
            block_avg_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_BLOCK_SIZE: begin
                        blk_size_reg = cfg_data[6:0];
                    end
                    REG_IMAGE_WIDTH: begin
                        img_width_reg = cfg_data;
                    end
                    REG_IMAGE_HEIGHT: begin
                        img_height_reg = cfg_data;
                    end
                    default: begin
                    end
                endcase
                home_position();
            end
            if (s_valid && s_ready) accumulate_pixel(s_data);
            if (m_valid && m_ready) begin
                if (block_avg_q.size() == 0) begin
                    report("result word with no block average pending");
                end else begin
                    want = block_avg_q.pop_front();
                    check_field("block_col", m_data.block_col, want.block_col);
                    check_field("block_row", m_data.block_row, want.block_row);
                    check_field("avg_red", m_data.avg_red, want.avg_red);
                    check_field("avg_green", m_data.avg_green, want.avg_green);
                    check_field("avg_blue", m_data.avg_blue, want.avg_blue);
                    check_field("frame_done", m_data.frame_done, want.frame_done);
                end
            end
        end
        pending <= block_avg_q.size();
    end

endmodule

### tb/block_mosaic_averager_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Block mosaic averager testbench
// Drives pixel frames and register writes with random gaps and stalls,
// including a long result stall, and reports the checker's verdict.
// ---------------------------------------------------------------------------
module block_mosaic_averager_tb;
    import bma_pkg::*;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 1000000;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    pixel_t      s_data;
    logic        m_valid;
    logic        m_ready;
    result_t     m_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [10:0] cfg_data;
    int          errors;
    int          pending;
    int          cycles;
    bit          calm;
    int          hold_seq;
    int          hold_seen;
    int          rx_wait;
    int          rand_pixels;
    int          cur_w, cur_h;

    block_mosaic_averager i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    block_mosaic_averager_check i_check (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    initial aclk = 1'b0;
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("block_mosaic_averager verification failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        int r;
        r = $urandom_range(0, 99);
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait <= 0;
        end else if (hold_seen != hold_seq) begin
            hold_seen <= hold_seq;
            m_ready   <= 1'b0;
            rx_wait   <= 400;
        end else if (rx_wait > 0) begin
            rx_wait <= rx_wait - 1;
            m_ready <= 1'b0;
        end else if (calm || r < 70) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= 1'b0;
            rx_wait <= (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
        end
    end

    function automatic int eff_dim(input int v, input int hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    task automatic send_pixel(input int r, input int g, input int b, input bit fs);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 99) < 30)
            gap = ($urandom_range(0, 9) < 9) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{red: r[7:0], green: g[7:0], blue: b[7:0], frame_start: fs};
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_random(input int n, input bit first_fs);
        for (int i = 0; i < n; i++)
            send_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 255), (i == 0) && first_fs);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int value);
        drain();
        if (idx == REG_IMAGE_WIDTH) cur_w = eff_dim(value, DEF_MAX_WIDTH);
        if (idx == REG_IMAGE_HEIGHT) cur_h = eff_dim(value, DEF_MAX_HEIGHT);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[10:0];
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_shape(input int bs, input int w, input int h);
        write_reg(REG_BLOCK_SIZE, bs);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
    endtask

    initial begin
        int frames, len;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        cycles    = 0;
        calm      = 1'b0;
        hold_seq  = 0;
        hold_seen = 0;
        cur_w     = 1024;
        cur_h     = 1024;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        send_pixel(255, 255, 255, 1'b1);
        send_pixel(0, 0, 0, 1'b0);
        send_pixel(255, 0, 255, 1'b0);
        send_pixel(0, 255, 0, 1'b0);
        send_pixel(170, 85, 170, 1'b1);
        send_pixel(85, 170, 85, 1'b0);

        set_shape(3, 7, 5);
        send_random(35, 1'b1);
        send_random(35, 1'b0);
        send_random(10, 1'b0);
        send_random(35, 1'b1);

        set_shape(0, 0, 0);
        send_random(4, 1'b0);

        set_shape(127, 5, 3);
        send_pixel(255, 255, 255, 1'b1);
        for (int i = 0; i < 14; i++) send_pixel(255, 255, 255, 1'b0);
        send_random(7, 1'b0);
        write_reg(REG_UNUSED, 2047);
        send_random(15, 1'b0);

        set_shape(2, 2047, 1);
        send_random(200, 1'b1);
        write_reg(REG_IMAGE_WIDTH, 1);
        write_reg(REG_IMAGE_HEIGHT, 2047);
        send_random(100, 1'b1);

        set_shape(1, 8, 8);
        calm = 1'b1;
        hold_seq++;
        send_random(64, 1'b1);
        drain();
        calm = 1'b0;

        rand_pixels = 0;
        while (rand_pixels < 180) begin
            if ($urandom_range(0, 4) == 0)
                set_shape($urandom_range(0, 127), $urandom_range(1, 16), $urandom_range(1, 8));
            else
                set_shape($urandom_range(1, 6), $urandom_range(1, 16), $urandom_range(1, 8));
            calm = ($urandom_range(0, 3) == 0);
            frames = $urandom_range(1, 2);
            for (int f = 0; f < frames; f++) begin
                len = cur_w * cur_h;
                if ($urandom_range(0, 7) == 0) begin
                    len = $urandom_range(1, 20);
                    for (int i = 0; i < len; i++)
                        send_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                                   $urandom_range(0, 255), $urandom_range(0, 1));
                end else begin
                    if ($urandom_range(0, 5) == 0) len = $urandom_range(1, len);
                    send_random(len, 1'b1);
                end
                rand_pixels += len;
            end
        end
        calm = 1'b0;

        drain();
        repeat (30) @(posedge aclk);
        if (errors == 0) begin
            $display("block_mosaic_averager verification clean");
        end else begin
            $display("block_mosaic_averager verification failed");
        end
        $finish;
    end

endmodule
